### src/assert_macros.svh
// Assertion macros included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define CHK_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define CHK_IMPL(lbl, clk, rst, a, c)
`define CHK_NEXT(lbl, clk, rst, a, c)
`endif
`endif

### src/cda_pkg.sv
// Types, constants and date functions of the calendar date unit.
package cda_pkg;

  typedef enum logic [1:0] {
    FN_DIFF = 2'd0,
    FN_ADD  = 2'd1,
    FN_CMP  = 2'd2,
    FN_DOY  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD_A = 2'd1,
    ST_BAD_B = 2'd2,
    ST_RANGE = 2'd3
  } stat_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DA,
    OP_DB,
    OP_SINIT,
    OP_SY,
    OP_SR,
    OP_SM,
    OP_FIN
  } op_t;

  typedef struct packed {
    op_t   op;
    stat_t st;
  } cda_cmd_t;

  typedef struct packed {
    func_t func;
    logic  a_ok;
    logic  b_ok;
    logic  diff_ovf;
    logic  range_ok;
    logic  search_done;
    logic  walk_done;
    logic  out_free;
  } cda_sts_t;

  localparam int YEAR_FIELD_MAX = 16383;
  localparam int COUNT_MAX      = 4194303;
  localparam logic [13:0] BASE_RESET = 14'd1900;

  // month length, leap flag selects the February entry
  function automatic logic [4:0] month_len(input logic lp, input logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      4'd2: r = lp ? 5'd29 : 5'd28;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // days of a common year before the first of month m
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1: r = 9'd0;
      4'd2: r = 9'd31;
      4'd3: r = 9'd59;
      4'd4: r = 9'd90;
      4'd5: r = 9'd120;
      4'd6: r = 9'd151;
      4'd7: r = 9'd181;
      4'd8: r = 9'd212;
      4'd9: r = 9'd243;
      4'd10: r = 9'd273;
      4'd11: r = 9'd304;
      4'd12: r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // y mod 25 via reciprocal multiply, exact for y < 2^15
  function automatic logic is_leap(input logic [14:0] y);
    logic [31:0] q;
    logic [31:0] r;
    q = ({17'd0, y} * 32'd5243) >> 17;
    r = {17'd0, y} - q * 32'd25;
    return (y[1:0] == 2'd0) && ((r != 32'd0) || (y[3:0] == 4'd0));
  endfunction

  // days in years 0 .. y-1
  function automatic logic [23:0] days_before(input logic [14:0] y);
    logic [31:0] yy;
    logic [31:0] s;
    yy = {17'd0, y};
    s = yy * 32'd365 + ((yy + 32'd3) >> 2)
        - (((yy + 32'd99) * 32'd5243) >> 19)
        + ((((yy + 32'd399) >> 2) * 32'd5243) >> 19);
    return s[23:0];
  endfunction

  function automatic logic [8:0] year_day(input logic [4:0] d, input logic [3:0] m,
                                          input logic [13:0] y);
    logic [8:0] s;
    s = cum_days(m) + {4'd0, d};
    if (is_leap({1'b0, y}) && m > 4'd2) s = s + 9'd1;
    return s;
  endfunction

endpackage

### src/cda_ctrl.sv
// Sequencer of the calendar date unit.
module cda_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  cda_pkg::cda_sts_t sts,
  output cda_pkg::cda_cmd_t cmd
);
  import cda_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_DA, S_DB, S_DCHK, S_SY, S_SR, S_SM, S_FIN
  } state_t;

  state_t state;
  stat_t  st;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd.op = OP_NONE;
    cmd.st = st;
    case (state)
      S_IDLE: if (in_valid) cmd.op = OP_LOAD;
      S_DA:   cmd.op = OP_DA;
      S_DB:   cmd.op = OP_DB;
      S_DCHK: if (sts.func == FN_ADD && sts.range_ok) cmd.op = OP_SINIT;
      S_SY:   cmd.op = OP_SY;
      S_SR:   cmd.op = OP_SR;
      S_SM:   cmd.op = OP_SM;
      S_FIN:  if (sts.out_free) cmd.op = OP_FIN;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      st <= ST_OK;
    end else begin
      case (state)
        S_IDLE: if (in_valid) state <= S_CHK;
        S_CHK: begin
          if (!sts.a_ok) begin
            st <= ST_BAD_A;
            state <= S_FIN;
          end else if ((sts.func == FN_DIFF || sts.func == FN_CMP) && !sts.b_ok) begin
            st <= ST_BAD_B;
            state <= S_FIN;
          end else begin
            st <= ST_OK;
            state <= (sts.func == FN_DIFF || sts.func == FN_ADD) ? S_DA : S_FIN;
          end
        end
        S_DA: state <= S_DB;
        S_DB: state <= S_DCHK;
        S_DCHK: begin
          if (sts.func == FN_DIFF) begin
            st <= sts.diff_ovf ? ST_RANGE : ST_OK;
            state <= S_FIN;
          end else if (sts.range_ok) begin
            state <= S_SY;
          end else begin
            st <= ST_RANGE;
            state <= S_FIN;
          end
        end
        S_SY: if (sts.search_done) state <= S_SR;
        S_SR: state <= S_SM;
        S_SM: if (sts.walk_done) state <= S_FIN;
        S_FIN: if (sts.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/cda_dp.sv
// Datapath of the calendar date unit: day counts, year search, month walk.
module cda_dp #(
  parameter int LIM = 9999
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [13:0]       cfg_data,
  input  cda_pkg::cda_cmd_t cmd,
  output cda_pkg::cda_sts_t sts,
  input  logic [1:0]        func,
  input  logic [4:0]        day_a,
  input  logic [3:0]        month_a,
  input  logic [13:0]       year_a,
  input  logic [4:0]        day_b,
  input  logic [3:0]        month_b,
  input  logic [13:0]       year_b,
  input  logic signed [22:0] offset_days,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [4:0]        res_day,
  output logic [3:0]        res_month,
  output logic [13:0]       res_year,
  output logic [21:0]       day_count,
  output logic signed [14:0] cmp_value,
  output logic [1:0]        status
);
  import cda_pkg::*;

  localparam logic [14:0] LIM_P1 = 15'(LIM + 1);

  logic [13:0] base_year;
  func_t       fn;
  logic [4:0]  da, dbd;
  logic [3:0]  ma, mb;
  logic [13:0] ya, yb;
  logic signed [22:0] off;
  logic [14:0] arg;
  logic signed [25:0] acc;
  logic [23:0] lo;
  logic [13:0] yv;
  logic [3:0]  bitpos;
  logic [3:0]  mon;

  logic [23:0] dbv;
  logic signed [25:0] dbs;
  logic [8:0]  yday_a, yday_b;
  logic        a_ok, b_ok, hit, step;
  logic [13:0] ynew;
  logic [4:0]  mlen;
  logic signed [25:0] t;

  function automatic logic date_ok(input logic [4:0] d, input logic [3:0] m,
                                   input logic [13:0] y, input logic [13:0] b);
    return ({1'b0, y} >= {1'b0, b}) && ({18'd0, y} <= 32'(LIM))
           && m >= 4'd1 && m <= 4'd12 && d >= 5'd1
           && d <= month_len(is_leap({1'b0, y}), m);
  endfunction

  assign dbv    = days_before(arg);
  assign dbs    = $signed({2'b00, dbv});
  assign yday_a = year_day(da, ma, ya);
  assign yday_b = year_day(dbd, mb, yb);
  assign a_ok   = date_ok(da, ma, ya, base_year);
  assign b_ok   = date_ok(dbd, mb, yb, base_year);
  assign hit    = dbs < acc;
  assign ynew   = hit ? arg[13:0] : yv;
  assign mlen   = month_len(is_leap({1'b0, yv}), mon);
  assign step   = (mon < 4'd12) && (acc > $signed({21'd0, mlen}));
  assign t      = acc - (dbs + $signed({17'd0, yday_b}));

  assign sts.func        = fn;
  assign sts.a_ok        = a_ok;
  assign sts.b_ok        = b_ok;
  assign sts.diff_ovf    = acc > 26'sd4194303;
  assign sts.range_ok    = (acc >= $signed({2'b00, lo}) + 26'sd1) && (acc <= dbs);
  assign sts.search_done = (bitpos == 4'd0);
  assign sts.walk_done   = !step;
  assign sts.out_free    = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_year <= BASE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) base_year <= cfg_data;
      if (cmd.op == OP_FIN) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        fn <= func_t'(func);
        da <= day_a; ma <= month_a; ya <= year_a;
        dbd <= day_b; mb <= month_b; yb <= year_b;
        off <= offset_days;
        arg <= {1'b0, year_a};
      end
      OP_DA: begin
        acc <= dbs + $signed({17'd0, yday_a});
        arg <= (fn == FN_DIFF) ? {1'b0, yb} : {1'b0, base_year};
      end
      OP_DB: begin
        if (fn == FN_DIFF) begin
          acc <= (t < 0) ? -t : t;
        end else begin
          acc <= acc + 26'(off);
          lo  <= dbv;
          arg <= LIM_P1;
        end
      end
      OP_SINIT: begin
        yv <= '0;
        bitpos <= 4'd13;
        arg <= 15'd8192;
      end
      OP_SY: begin
        yv <= ynew;
        if (bitpos != 4'd0) begin
          bitpos <= bitpos - 4'd1;
          arg <= {1'b0, ynew | (14'd1 << (bitpos - 4'd1))};
        end else begin
          arg <= {1'b0, ynew};
        end
      end
      OP_SR: begin
        acc <= acc - dbs;
        mon <= 4'd1;
      end
      OP_SM: begin
        if (step) begin
          acc <= acc - $signed({21'd0, mlen});
          mon <= mon + 4'd1;
        end
      end
      OP_FIN: begin
        res_day <= '0; res_month <= '0; res_year <= '0;
        day_count <= '0; cmp_value <= '0;
        status <= cmd.st;
        if (cmd.st == ST_OK) begin
          case (fn)
            FN_DIFF: day_count <= acc[21:0];
            FN_ADD: begin
              res_day <= acc[4:0];
              res_month <= mon;
              res_year <= yv;
            end
            FN_CMP: begin
              if (ya != yb) cmp_value <= $signed({1'b0, ya}) - $signed({1'b0, yb});
              else if (ma != mb)
                cmp_value <= $signed({11'd0, ma}) - $signed({11'd0, mb});
              else cmp_value <= $signed({10'd0, da}) - $signed({10'd0, dbd});
            end
            FN_DOY: day_count <= {13'd0, yday_a};
            default: day_count <= '0;
          endcase
        end
      end
      default: ;
    endcase
  end

endmodule

### src/calendar_date_arithmetic_unit.sv
// Gregorian date unit: day difference, date plus days, compare, day of year.
// Usage:
//   Requests enter on in_valid/in_stall; a transfer happens when in_valid
//   is high and in_stall low. One result per request leaves on
//   out_valid/out_stall, held steady while out_stall is high.
//   base_year is written through cfg_we/cfg_data; the user must do so only
//   while the unit is idle, which the unit does not enforce. Compare, day of
//   year and invalid dates go from the check state to the output; day
//   difference and out-of-range adds first pass the two day-count states
//   and the range check. Add days then runs a 14-step binary year search
//   through the shared days-before-year unit and a month walk of up to 11 steps.
// Throughput: one request at a time; a new request is taken as soon as
//   the previous result sits in the output register, even while stalled.
// Reset (rst, synchronous): sequencer idle, no result pending,
//   base_year back to 1900.
// Stall: a stalled result holds; the finished next request waits in the
//   sequencer until the output register frees.
module calendar_date_arithmetic_unit #(
  parameter int YEAR_LIMIT = 9999
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [13:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         func,
  input  logic [4:0]         day_a,
  input  logic [3:0]         month_a,
  input  logic [13:0]        year_a,
  input  logic [4:0]         day_b,
  input  logic [3:0]         month_b,
  input  logic [13:0]        year_b,
  input  logic signed [22:0] offset_days,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         res_day,
  output logic [3:0]         res_month,
  output logic [13:0]        res_year,
  output logic [21:0]        day_count,
  output logic signed [14:0] cmp_value,
  output logic [1:0]         status
);
  import cda_pkg::*;
`include "assert_macros.svh"

  localparam int LIM = (YEAR_LIMIT < YEAR_FIELD_MAX) ? YEAR_LIMIT : YEAR_FIELD_MAX;

  cda_cmd_t cmd;
  cda_sts_t sts;

  cda_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .cmd(cmd)
  );

  cda_dp #(.LIM(LIM)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .cmd(cmd), .sts(sts), .func(func),
    .day_a(day_a), .month_a(month_a), .year_a(year_a),
    .day_b(day_b), .month_b(month_b), .year_b(year_b),
    .offset_days(offset_days), .out_stall(out_stall), .out_valid(out_valid),
    .res_day(res_day), .res_month(res_month), .res_year(res_year),
    .day_count(day_count), .cmp_value(cmp_value), .status(status)
  );

  `CHK_IMPL(a_fault_zero, clk, rst, out_valid && status != ST_OK, res_day == 5'd0 && day_count == 22'd0 && cmp_value == 15'sd0)
  `CHK_NEXT(a_busy_after_xfer, clk, rst, in_valid && !in_stall, in_stall)
  `CHK_IMPL(a_month_range, clk, rst, out_valid && status == ST_OK, res_month <= 4'd12)

endmodule
